// ===== rtl/mvna_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the mesh vertex normal accumulator.
package mvna_pkg;

    localparam int VERTEX_DEPTH   = 1024;
    localparam int TRIANGLE_LIMIT = 2048;
    localparam int COORD_W        = 16;

    localparam int VADDR_W = $clog2(VERTEX_DEPTH);
    localparam int VCNT_W  = $clog2(VERTEX_DEPTH + 1);
    localparam int TCNT_W  = $clog2(TRIANGLE_LIMIT + 1);
    localparam int POS_W   = 3 * COORD_W;
    localparam int SUM_W   = 48;
    localparam int SUMS_W  = 3 * SUM_W;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int FACE_W  = PROD_W + 1;
    localparam int MUL_W   = 32;
    localparam int MAG_W   = 31;
    localparam int SQ_W    = 64;
    localparam int LEN_W   = 32;
    localparam int FRAC_W  = 14;
    localparam int QUO_W   = FRAC_W + 1;
    localparam int REM_W   = MAG_W + FRAC_W + 2;
    localparam int NORM_W  = 16;
    localparam int CNT_W   = 5;

    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(6);
    localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(3);
    localparam logic [CNT_W-1:0] SQRT_TOP  = CNT_W'(SQ_W / 2 - 1);
    localparam logic [CNT_W-1:0] DIV_TOP   = CNT_W'(QUO_W - 1);
    localparam logic [CNT_W-1:0] LAST_CORNER = CNT_W'(2);
    localparam logic [1:0]       LAST_COMP = 2'd2;

    localparam logic [1:0] REQ_CLEAR    = 2'd0;
    localparam logic [1:0] REQ_VERTEX   = 2'd1;
    localparam logic [1:0] REQ_TRIANGLE = 2'd2;
    localparam logic [1:0] REQ_READ     = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    localparam logic CFG_VCAP = 1'b0;
    localparam logic CFG_TCAP = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TRI_RA,
        ST_TRI_RB,
        ST_TRI_RC,
        ST_TRI_RW,
        ST_MUL,
        ST_FACE,
        ST_SUM_RD,
        ST_SUM_WR,
        ST_RD_ISSUE,
        ST_RD_MAG,
        ST_SHIFT,
        ST_SQ,
        ST_SQRT,
        ST_LEN,
        ST_DIV_INIT,
        ST_DIV,
        ST_DIV_END,
        ST_DONE
    } state_t;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                                 input logic signed [FACE_W-1:0] d);
        logic signed [SUM_W:0] r;
        r = (SUM_W+1)'(signed'(acc)) + (SUM_W+1)'(d);
        if (r[SUM_W] != r[SUM_W-1]) begin
            sat_add = r[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else begin
            sat_add = r[SUM_W-1:0];
        end
    endfunction

    function automatic logic [SUM_W-1:0] mag_of(input logic [SUM_W-1:0] s);
        mag_of = s[SUM_W-1] ? (~s + SUM_W'(1)) : s;
    endfunction

endpackage

// ===== rtl/mvna_ram.sv =====
`timescale 1ns / 1ps
// Simple dual-port RAM with one write port and one registered read port.
module mvna_ram #(
    parameter int DATA_W = 48,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [1 << ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mesh_vertex_normal_accumulator.sv =====
`timescale 1ns / 1ps
// Top level: mesh store, sequencer and shared multiply, root and divide datapath.
//
//  Channel | Signals                                          | Direction
//  --------+--------------------------------------------------+----------
//  request | in_valid/in_ready, req_type, pos_*, corner_*     | in
//  result  | out_valid/out_ready, status, item_index, normal_*| out
//  config  | cfg_valid/cfg_ready, cfg_index, cfg_data         | in
//
// Clear and vertex transactions complete straight from decode, triangles make three
// read-modify-writes of the sum memory, and reads make up to 17 normalising shifts,
// 32 root steps and three 15-step divisions on one shared unit.
// After reset both counts are zero and the block is ready at once. A result waiting
// on the output register does not block acceptance, only the completion of the next.
module mesh_vertex_normal_accumulator
    import mvna_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] pos_z,
    input  logic [9:0]         corner_a,
    input  logic [9:0]         corner_b,
    input  logic [9:0]         corner_c,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [10:0]        item_index,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic signed [15:0] normal_z,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [11:0]        cfg_data
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [1:0]         comp_reg, comp_next;
    logic [VCNT_W-1:0]  vcount_reg;
    logic [TCNT_W-1:0]  tcount_reg;
    logic [10:0]        vcap_reg;
    logic [11:0]        tcap_reg;
    logic               out_valid_reg;

    logic [1:0]         req_reg;
    logic [9:0]         ca_reg, cb_reg, cc_reg;
    logic [POS_W-1:0]   pos_in_reg;
    logic [POS_W-1:0]   pa_reg, pb_reg, pc_reg;
    logic signed [2*MUL_W-1:0] prod_reg;
    logic signed [PROD_W-1:0]  prods_reg [6];
    logic signed [FACE_W-1:0]  face_reg [3];
    logic [SUM_W-1:0]   mag_reg [3];
    logic [2:0]         sign_reg;
    logic [SQ_W-1:0]    acc_reg;
    logic [SQ_W-1:0]    root_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic [1:0]         res_status_reg;
    logic [10:0]        res_index_reg;
    logic [NORM_W-1:0]  res_norm_reg [3];
    logic [1:0]         status_reg;
    logic [10:0]        index_reg;
    logic [NORM_W-1:0]  nx_reg, ny_reg, nz_reg;

    logic [VCNT_W-1:0]  vcap_eff;
    logic [TCNT_W-1:0]  tcap_eff;
    logic               vfull, tfull, corner_bad, read_bad, big, go, accept;
    logic [VADDR_W-1:0] corner_sel;
    logic [POS_W-1:0]   pos_rdata;
    logic [SUMS_W-1:0]  sum_rdata, sum_wdata;
    logic               pos_we, sum_we;
    logic [VADDR_W-1:0] pos_raddr, sum_raddr, sum_waddr;
    logic signed [DIFF_W-1:0] u [3];
    logic signed [DIFF_W-1:0] w [3];
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p;
    logic [SQ_W-1:0]    sq_bit, sq_trial;
    logic [REM_W-1:0]   div_d;
    logic [MAG_W-1:0]   mag_sel;
    logic [LEN_W-1:0]   len;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign go        = !out_valid_reg || out_ready;

    assign vcap_eff = (vcap_reg > 11'(VERTEX_DEPTH)) ? VCNT_W'(VERTEX_DEPTH)
                                                     : VCNT_W'(vcap_reg);
    assign tcap_eff = (tcap_reg > 12'(TRIANGLE_LIMIT)) ? TCNT_W'(TRIANGLE_LIMIT)
                                                       : TCNT_W'(tcap_reg);
    assign vfull      = (vcount_reg >= vcap_eff);
    assign tfull      = (tcount_reg >= tcap_eff);
    assign read_bad   = (VCNT_W'(ca_reg) >= vcount_reg);
    assign corner_bad = read_bad || (VCNT_W'(cb_reg) >= vcount_reg)
                                 || (VCNT_W'(cc_reg) >= vcount_reg);
    assign big = (|mag_reg[0][SUM_W-1:MAG_W]) || (|mag_reg[1][SUM_W-1:MAG_W])
                                              || (|mag_reg[2][SUM_W-1:MAG_W]);
    assign len = root_reg[LEN_W-1:0];

    always_comb
    begin
        case (cnt_reg)
            CNT_W'(0): corner_sel = VADDR_W'(ca_reg);
            CNT_W'(1): corner_sel = VADDR_W'(cb_reg);
            default:   corner_sel = VADDR_W'(cc_reg);
        endcase
    end

    always_comb
    begin
        case (comp_reg)
            2'd0:    mag_sel = mag_reg[0][MAG_W-1:0];
            2'd1:    mag_sel = mag_reg[1][MAG_W-1:0];
            default: mag_sel = mag_reg[2][MAG_W-1:0];
        endcase
    end

    // Position store
    assign pos_we = (state_reg == ST_DECODE) && (req_reg == REQ_VERTEX) && !vfull;
    always_comb
    begin
        case (state_reg)
            ST_TRI_RB: pos_raddr = VADDR_W'(cb_reg);
            ST_TRI_RC: pos_raddr = VADDR_W'(cc_reg);
            default:   pos_raddr = VADDR_W'(ca_reg);
        endcase
    end

    mvna_ram #(
        .DATA_W (POS_W),
        .ADDR_W (VADDR_W)
    ) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (vcount_reg[VADDR_W-1:0]),
        .wdata (pos_in_reg),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    // Normal sum store
    assign sum_we    = pos_we || (state_reg == ST_SUM_WR);
    assign sum_waddr = (state_reg == ST_SUM_WR) ? corner_sel : vcount_reg[VADDR_W-1:0];
    assign sum_raddr = (state_reg == ST_RD_ISSUE) ? VADDR_W'(ca_reg) : corner_sel;
    always_comb
    begin
        if (state_reg == ST_SUM_WR)
        begin
            sum_wdata = {sat_add(sum_rdata[2*SUM_W +: SUM_W], face_reg[2]),
                         sat_add(sum_rdata[SUM_W +: SUM_W], face_reg[1]),
                         sat_add(sum_rdata[0 +: SUM_W], face_reg[0])};
        end
        else
        begin
            sum_wdata = '0;
        end
    end

    mvna_ram #(
        .DATA_W (SUMS_W),
        .ADDR_W (VADDR_W)
    ) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    // Edge vectors and the shared multiplier
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u[i] = DIFF_W'(signed'(pb_reg[i*COORD_W +: COORD_W]))
                 - DIFF_W'(signed'(pa_reg[i*COORD_W +: COORD_W]));
            w[i] = DIFF_W'(signed'(pc_reg[i*COORD_W +: COORD_W]))
                 - DIFF_W'(signed'(pa_reg[i*COORD_W +: COORD_W]));
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_MUL)
        begin
            case (cnt_reg)
                CNT_W'(0): begin mul_a = MUL_W'(u[1]); mul_b = MUL_W'(w[2]); end
                CNT_W'(1): begin mul_a = MUL_W'(u[2]); mul_b = MUL_W'(w[1]); end
                CNT_W'(2): begin mul_a = MUL_W'(u[2]); mul_b = MUL_W'(w[0]); end
                CNT_W'(3): begin mul_a = MUL_W'(u[0]); mul_b = MUL_W'(w[2]); end
                CNT_W'(4): begin mul_a = MUL_W'(u[0]); mul_b = MUL_W'(w[1]); end
                CNT_W'(5): begin mul_a = MUL_W'(u[1]); mul_b = MUL_W'(w[0]); end
                default:   begin mul_a = '0; mul_b = '0; end
            endcase
        end
        else if (state_reg == ST_SQ)
        begin
            case (cnt_reg)
                CNT_W'(0): mul_a = MUL_W'({1'b0, mag_reg[0][MAG_W-1:0]});
                CNT_W'(1): mul_a = MUL_W'({1'b0, mag_reg[1][MAG_W-1:0]});
                default:   mul_a = MUL_W'({1'b0, mag_reg[2][MAG_W-1:0]});
            endcase
            mul_b = mul_a;
        end
    end

    assign mul_p    = mul_a * mul_b;
    assign sq_bit   = SQ_W'(1) << {cnt_reg, 1'b0};
    assign sq_trial = root_reg + sq_bit;
    assign div_d    = REM_W'(len) << cnt_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (req_reg)
                    REQ_TRIANGLE: state_next = (tfull || corner_bad) ? ST_DONE : ST_TRI_RA;
                    REQ_READ:     state_next = read_bad ? ST_DONE : ST_RD_ISSUE;
                    default:      state_next = ST_DONE;
                endcase
            end
            ST_TRI_RA: state_next = ST_TRI_RB;
            ST_TRI_RB: state_next = ST_TRI_RC;
            ST_TRI_RC: state_next = ST_TRI_RW;
            ST_TRI_RW:
            begin
                state_next = ST_MUL;
                cnt_next   = '0;
            end
            ST_MUL:
            begin
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = ST_FACE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_FACE:
            begin
                state_next = ST_SUM_RD;
                cnt_next   = '0;
            end
            ST_SUM_RD: state_next = ST_SUM_WR;
            ST_SUM_WR:
            begin
                if (cnt_reg == LAST_CORNER)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SUM_RD;
                    cnt_next   = cnt_reg + CNT_W'(1);
                end
            end
            ST_RD_ISSUE: state_next = ST_RD_MAG;
            ST_RD_MAG:   state_next = ST_SHIFT;
            ST_SHIFT:
            begin
                if (!big)
                begin
                    state_next = ST_SQ;
                    cnt_next   = '0;
                end
            end
            ST_SQ:
            begin
                if (cnt_reg == SQ_LAST)
                begin
                    state_next = ST_SQRT;
                    cnt_next   = SQRT_TOP;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_SQRT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_LEN;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_LEN:
            begin
                if (len == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DIV_INIT;
                    comp_next  = '0;
                end
            end
            ST_DIV_INIT:
            begin
                state_next = ST_DIV;
                cnt_next   = DIV_TOP;
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_DIV_END;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_DIV_END:
            begin
                if (comp_reg == LAST_COMP)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DIV_INIT;
                    comp_next  = comp_reg + 2'd1;
                end
            end
            ST_DONE:
            begin
                if (go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            comp_reg      <= '0;
            vcount_reg    <= '0;
            tcount_reg    <= '0;
            vcap_reg      <= 11'(VERTEX_DEPTH);
            tcap_reg      <= 12'(TRIANGLE_LIMIT);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_VCAP: vcap_reg <= cfg_data[10:0];
                    default:  tcap_reg <= cfg_data;
                endcase
            end
            if (state_reg == ST_DECODE)
            begin
                if (req_reg == REQ_CLEAR)
                begin
                    vcount_reg <= '0;
                    tcount_reg <= '0;
                end
                else if (pos_we)
                begin
                    vcount_reg <= vcount_reg + VCNT_W'(1);
                end
            end
            if ((state_reg == ST_SUM_WR) && (cnt_reg == LAST_CORNER))
            begin
                tcount_reg <= tcount_reg + TCNT_W'(1);
            end
            if ((state_reg == ST_DONE) && go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_reg    <= req_type;
                    ca_reg     <= corner_a;
                    cb_reg     <= corner_b;
                    cc_reg     <= corner_c;
                    pos_in_reg <= {pos_z[COORD_W-1:0], pos_y[COORD_W-1:0], pos_x[COORD_W-1:0]};
                end
            end
            ST_DECODE:
            begin
                res_status_reg  <= STATUS_OK;
                res_index_reg   <= '0;
                res_norm_reg[0] <= '0;
                res_norm_reg[1] <= '0;
                res_norm_reg[2] <= '0;
                case (req_reg)
                    REQ_VERTEX:
                    begin
                        if (vfull)
                        begin
                            res_status_reg <= STATUS_FULL;
                        end
                        else
                        begin
                            res_index_reg <= 11'(vcount_reg);
                        end
                    end
                    REQ_TRIANGLE:
                    begin
                        if (tfull)
                        begin
                            res_status_reg <= STATUS_FULL;
                        end
                        else if (corner_bad)
                        begin
                            res_status_reg <= STATUS_RANGE;
                        end
                    end
                    REQ_READ:
                    begin
                        res_index_reg <= 11'(ca_reg);
                        if (read_bad)
                        begin
                            res_status_reg <= STATUS_RANGE;
                        end
                    end
                    default:
                    begin
                        res_index_reg <= '0;
                    end
                endcase
            end
            ST_TRI_RB: pa_reg <= pos_rdata;
            ST_TRI_RC: pb_reg <= pos_rdata;
            ST_TRI_RW: pc_reg <= pos_rdata;
            ST_MUL:
            begin
                if (cnt_reg != '0)
                begin
                    prods_reg[3'(cnt_reg - CNT_W'(1))] <= prod_reg[PROD_W-1:0];
                end
            end
            ST_FACE:
            begin
                face_reg[0] <= FACE_W'(prods_reg[0]) - FACE_W'(prods_reg[1]);
                face_reg[1] <= FACE_W'(prods_reg[2]) - FACE_W'(prods_reg[3]);
                face_reg[2] <= FACE_W'(prods_reg[4]) - FACE_W'(prods_reg[5]);
            end
            ST_SUM_WR:
            begin
                if (cnt_reg == LAST_CORNER)
                begin
                    res_index_reg <= 11'(tcount_reg);
                end
            end
            ST_RD_MAG:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mag_reg[i]  <= mag_of(sum_rdata[i*SUM_W +: SUM_W]);
                    sign_reg[i] <= sum_rdata[i*SUM_W + SUM_W - 1];
                end
            end
            ST_SHIFT:
            begin
                if (big)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                end
            end
            ST_SQ:
            begin
                if (cnt_reg == '0)
                begin
                    acc_reg  <= '0;
                    root_reg <= '0;
                end
                else
                begin
                    acc_reg <= acc_reg + SQ_W'(prod_reg);
                end
            end
            ST_SQRT:
            begin
                if (acc_reg >= sq_trial)
                begin
                    acc_reg  <= acc_reg - sq_trial;
                    root_reg <= (root_reg >> 1) + sq_bit;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
            end
            ST_DIV_INIT:
            begin
                rem_reg <= (REM_W'(mag_sel) << FRAC_W) + REM_W'(len >> 1);
                quo_reg <= '0;
            end
            ST_DIV:
            begin
                if (rem_reg >= div_d)
                begin
                    rem_reg          <= rem_reg - div_d;
                    quo_reg[cnt_reg[3:0]] <= 1'b1;
                end
            end
            ST_DIV_END:
            begin
                res_norm_reg[comp_reg] <= sign_reg[comp_reg] ? (~NORM_W'(quo_reg) + NORM_W'(1))
                                                             : NORM_W'(quo_reg);
            end
            ST_DONE:
            begin
                if (go)
                begin
                    status_reg <= res_status_reg;
                    index_reg  <= res_index_reg;
                    nx_reg     <= res_norm_reg[0];
                    ny_reg     <= res_norm_reg[1];
                    nz_reg     <= res_norm_reg[2];
                end
            end
            default:
            begin
                prods_reg[0] <= prods_reg[0];
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign item_index = index_reg;
    assign normal_x   = signed'(nx_reg);
    assign normal_y   = signed'(ny_reg);
    assign normal_z   = signed'(nz_reg);

`ifndef SYNTHESIS
    a_vcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vcount_reg <= VCNT_W'(VERTEX_DEPTH))
        else $error("vertex count beyond store depth");

    a_tcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tcount_reg <= TCNT_W'(TRIANGLE_LIMIT))
        else $error("triangle count beyond limit");

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (len != '0))
        else $error("division started with zero length");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != STATUS_OK))
            |-> (normal_x == 0 && normal_y == 0 && normal_z == 0))
        else $error("failed transaction carries a normal");

    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (normal_x >= -16384 && normal_x <= 16384 && normal_y >= -16384
                       && normal_y <= 16384 && normal_z >= -16384 && normal_z <= 16384))
        else $error("normal component out of range");

    a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && go) |=> out_valid)
        else $error("completed transaction not presented");
`endif

endmodule
